// ----- src/clc_pkg.sv -----
// shared types and constants for the causal linear convolution block
`timescale 1ns / 1ps
`default_nettype none

package clc_pkg;

  // frame length after reset, clamped to the memory depth where that is smaller
  localparam int unsigned DEFAULT_LENGTH = 16;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } clc_state_e;

  typedef struct packed {
    logic start;     // take the input word, write both sample memories
    logic issue;     // read one tap pair into the multiply-accumulate
    logic load_out;  // move the finished sum into the output register
  } clc_cmd_t;

  typedef struct packed {
    logic k_at_pos;   // this issue reads the last tap pair
    logic pipe_busy;  // taps still in flight through read and multiply
    logic out_free;   // output register empty or being taken
  } clc_status_t;

endpackage

`default_nettype wire

// ----- src/clc_ram.sv -----
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module clc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/clc_controller.sv -----
// sequencing state machine: accept, tap loop, drain, hand-off to output
`timescale 1ns / 1ps
`default_nettype none

module clc_controller (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_valid_i,
  output logic                      s_ready_o,
  output clc_pkg::clc_cmd_t         cmd_o,
  input  wire clc_pkg::clc_status_t status_i
);

  import clc_pkg::*;

  clc_state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_MAC;
        end
      end
      S_MAC: begin
        cmd_o.issue = 1'b1;
        if (status_i.k_at_pos) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/clc_datapath.sv -----
// sample memories, frame position, multiply-accumulate and output register
`timescale 1ns / 1ps
`default_nettype none

module clc_datapath #(
  parameter int unsigned MAX_LENGTH   = 1024,
  parameter int unsigned SAMPLE_WIDTH = 16,
  localparam int unsigned IdxW  = $clog2(MAX_LENGTH),
  localparam int unsigned LenW  = IdxW + 1,
  localparam int unsigned ProdW = 2 * SAMPLE_WIDTH,
  localparam int unsigned SumW  = ProdW + IdxW
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [LenW-1:0]          cfg_wdata_i,
  input  wire logic [SAMPLE_WIDTH-1:0]  a_sample_i,
  input  wire logic [SAMPLE_WIDTH-1:0]  b_sample_i,
  input  wire clc_pkg::clc_cmd_t        cmd_i,
  output clc_pkg::clc_status_t          status_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [IdxW-1:0]               out_index_o,
  output logic [SAMPLE_WIDTH-1:0]       out_a_o,
  output logic [SAMPLE_WIDTH-1:0]       out_b_o,
  output logic [SumW-1:0]               out_sum_o,
  output logic                          out_last_o
);

  import clc_pkg::*;

  localparam int unsigned ResetLen =
    (DEFAULT_LENGTH > MAX_LENGTH) ? MAX_LENGTH : DEFAULT_LENGTH;

  logic [LenW-1:0]         len_q;
  logic [LenW-1:0]         eff_len;
  logic [IdxW-1:0]         fpos_q, fpos_d;
  logic [IdxW-1:0]         pos_q;
  logic [IdxW-1:0]         k_q;
  logic                    last_now;
  logic                    last_q;
  logic [SAMPLE_WIDTH-1:0] a_q, b_q;
  logic [SAMPLE_WIDTH-1:0] a_rd, b_rd;
  logic                    rd_vld_q;
  logic                    prod_vld_q;
  logic [ProdW-1:0]        prod_q;
  logic [SumW-1:0]         acc_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(ResetLen);
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  // zero acts as one, anything past the memory depth as the depth
  always_comb begin
    if (len_q == '0) begin
      eff_len = LenW'(1);
    end else if (len_q > LenW'(MAX_LENGTH)) begin
      eff_len = LenW'(MAX_LENGTH);
    end else begin
      eff_len = len_q;
    end
  end

  assign last_now = ({1'b0, fpos_q} + LenW'(1)) >= eff_len;
  assign fpos_d   = last_now ? '0 : fpos_q + IdxW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpos_q <= '0;
    end else if (cmd_i.start) begin
      fpos_q <= fpos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pos_q  <= fpos_q;
      last_q <= last_now;
      a_q    <= a_sample_i;
      b_q    <= b_sample_i;
    end
  end

  // tap counter: b is read forward, a backward from the current position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.start) begin
      k_q <= '0;
    end else if (cmd_i.issue) begin
      k_q <= k_q + IdxW'(1);
    end
  end

  clc_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_LENGTH)
  ) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.start),
    .waddr_i (fpos_q),
    .wdata_i (a_sample_i),
    .re_i    (cmd_i.issue),
    .raddr_i (pos_q - k_q),
    .rdata_o (a_rd)
  );

  clc_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_LENGTH)
  ) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.start),
    .waddr_i (fpos_q),
    .wdata_i (b_sample_i),
    .re_i    (cmd_i.issue),
    .raddr_i (k_q),
    .rdata_o (b_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.issue;
      prod_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= ProdW'($signed(a_rd)) * ProdW'($signed(b_rd));
    end
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + {{(SumW - ProdW){prod_q[ProdW-1]}}, prod_q};
    end
  end

  assign status_o.k_at_pos  = (k_q == pos_q);
  assign status_o.pipe_busy = rd_vld_q | prod_vld_q;
  assign status_o.out_free  = !out_valid_o || out_ready_i;

  // output register decouples the result from the next accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_index_o <= pos_q;
      out_a_o     <= a_q;
      out_b_o     <= b_q;
      out_sum_o   <= acc_q;
      out_last_o  <= last_q;
    end
  end

endmodule

`default_nettype wire

// ----- src/causal_linear_convolution.sv -----
// Causal truncated linear convolution of two streamed sample sequences.
// Each input word carries one signed sample of a and one of b; both are written
// to sample memories at the current frame position i, and one output word gives
// y[i] = sum over k = 0..i of a[i-k] * b[k] exactly (signed integer, no fraction), with i
// and both samples echoed and tlast set at position sequence_length - 1, after
// which the position restarts at 0. A single multiply-accumulate reads one tap
// pair from the two memories each cycle, so the word at position i occupies the
// block through one accept, i + 1 taps, the read and multiply drain, and the
// hand-off to the output register, which waits until that register is free; only then is the next word taken.
// The output register lets the next word be accepted while a result waits.
// Write sequence_length (0 acts as 1, values above MAX_LENGTH as MAX_LENGTH)
// only while the block is idle; its reset value is 16, or MAX_LENGTH if that is smaller.
`timescale 1ns / 1ps
`default_nettype none

module causal_linear_convolution #(
  parameter int unsigned MAX_LENGTH   = 1024,
  parameter int unsigned SAMPLE_WIDTH = 16,
  localparam int unsigned IdxW    = $clog2(MAX_LENGTH),
  localparam int unsigned LenW    = IdxW + 1,
  localparam int unsigned SumW    = 2 * SAMPLE_WIDTH + IdxW,
  localparam int unsigned InRawW  = 2 * SAMPLE_WIDTH,
  localparam int unsigned InW     = ((InRawW + 7) / 8) * 8,
  localparam int unsigned OutRawW = IdxW + 2 * SAMPLE_WIDTH + SumW,
  localparam int unsigned OutW    = ((OutRawW + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [LenW-1:0] cfg_wdata_i,   // sequence_length
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [InW-1:0]  s_axis_tdata,  // a_sample, b_sample
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [OutW-1:0]      m_axis_tdata,  // sample_index, a_echo, b_echo, conv_sum
  output logic                 m_axis_tlast   // frame_last
);

  import clc_pkg::*;

  clc_cmd_t                cmd;
  clc_status_t             status;
  logic [IdxW-1:0]         out_index;
  logic [SAMPLE_WIDTH-1:0] out_a, out_b;
  logic [SumW-1:0]         out_sum;

  clc_controller u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  clc_datapath #(
    .MAX_LENGTH   (MAX_LENGTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .a_sample_i  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .b_sample_i  (s_axis_tdata[InRawW-1:SAMPLE_WIDTH]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_index_o (out_index),
    .out_a_o     (out_a),
    .out_b_o     (out_b),
    .out_sum_o   (out_sum),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = OutW'({out_sum, out_b, out_a, out_index});

endmodule

`default_nettype wire

// ----- src/clc_checker.sv -----
// port-level assertions for the convolution block and their bind
`timescale 1ns / 1ps
`default_nettype none

module clc_checker #(
  parameter int unsigned OUT_W = 88
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata,
  input wire logic             m_axis_tlast
);

  // one word at a time: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while previous word still in work");

  // a new result only appears after input ready was low
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a busy cycle before it");

  // a new result never appears right after an input accept
  a_no_accept_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
    else $error("result appeared right after an accept");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output word changed");

endmodule

bind causal_linear_convolution clc_checker #(
  .OUT_W (OutW)
) u_clc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
